### rtl/rmi_pkg.sv
// Shared types and constants for the record marker indexer.
// Used by rmi_scan, rmi_out_queue, record_marker_indexer and rmi_checker.
`default_nettype none

package rmi_pkg;

    localparam int unsigned OUT_WIDTH   = 32;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_D      = 8'h64;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [7:0] {
        S_SEARCH  = 8'b0000_0001,
        S_NEWLINE = 8'b0000_0010,
        S_DOLLAR  = 8'b0000_0100,
        S_I       = 8'b0000_1000,
        S_D       = 8'b0001_0000,
        S_DIGITS  = 8'b0010_0000,
        S_CLOSE   = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } t_state;

    typedef enum logic [1:0] {
        KIND_CLOSED = 2'd0,
        KIND_FINAL  = 2'd1,
        KIND_EMPTY  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [OUT_WIDTH-1:0]   id;
        logic [OUT_WIDTH-1:0]   start;
        logic [OUT_WIDTH-1:0]   length;
        logic [OUT_WIDTH-1:0]   number;
        logic                   last;
    } t_result;

    // Results produced by one byte: count is 0, 1 or 2, first is used before second.
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

`default_nettype wire

### rtl/rmi_scan.sv
// Input register, marker recognizer and entry bookkeeping for one byte per cycle while the queue has room.
// Depends on rmi_pkg; hands its results to rmi_out_queue.
`default_nettype none

module rmi_scan #(
    parameter int unsigned POS_WIDTH = 32,
    parameter int unsigned ID_WIDTH  = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_end_of_file,
    input  wire logic           i_room,
    output rmi_pkg::t_push      o_push
);
    import rmi_pkg::*;

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_eof;

    t_state               r_state,      n_state;
    logic [ID_WIDTH-1:0]  r_id,         n_id;
    logic [POS_WIDTH-1:0] r_pos,        n_pos;
    logic [POS_WIDTH-1:0] r_line,       n_line;
    logic [ID_WIDTH-1:0]  r_open_id,    n_open_id;
    logic [POS_WIDTH-1:0] r_open_start, n_open_start;
    logic                 r_open_valid, n_open_valid;
    logic [OUT_WIDTH-1:0] r_count,      n_count;

    logic                 fire;
    logic                 is_digit;
    logic [ID_WIDTH-1:0]  digit;
    logic [POS_WIDTH-1:0] after;
    t_state               step_state;
    logic [ID_WIDTH-1:0]  step_id;
    logic [POS_WIDTH-1:0] step_line;
    logic [ID_WIDTH-1:0]  step_open_id;
    logic [POS_WIDTH-1:0] step_open_start;
    logic                 step_open_valid;
    logic [OUT_WIDTH-1:0] step_count;
    logic                 closes;
    t_result              closed_res;
    t_result              final_res;

    assign fire       = r_in_valid && i_room;
    assign o_in_ready = !r_in_valid || fire;

    assign is_digit = (r_in_byte >= CH_ZERO) && (r_in_byte <= CH_NINE);
    assign digit    = ID_WIDTH'(r_in_byte - CH_ZERO);
    assign after    = (&r_pos) ? r_pos : r_pos + 1'b1;

    always_comb begin
        step_state = S_SEARCH;
        step_id    = r_id;
        unique case (r_state)
            S_SEARCH:  step_state = (r_in_byte == CH_DOLLAR) ? S_DOLLAR : S_SEARCH;
            S_NEWLINE: step_state = (r_in_byte == CH_DOLLAR) ? S_DOLLAR : S_SEARCH;
            S_DOLLAR:  step_state = (r_in_byte == CH_I) ? S_I : S_SEARCH;
            S_I:       step_state = (r_in_byte == CH_D) ? S_D : S_SEARCH;
            S_D: begin
                if (r_in_byte == CH_COLON) begin
                    step_state = S_DIGITS;
                    step_id    = '0;
                end
            end
            S_DIGITS: begin
                if (is_digit) begin
                    step_state = S_DIGITS;
                    // Times ten as two shifts and an add; wraps at the id width.
                    step_id    = (r_id << 3) + (r_id << 1) + digit;
                end else if (r_in_byte == CH_DOLLAR) begin
                    step_state = S_CLOSE;
                end
            end
            S_CLOSE:   step_state = (r_in_byte == CH_NL) ? S_DONE : S_SEARCH;
            S_DONE:    step_state = (r_in_byte == CH_DOLLAR) ? S_DOLLAR : S_SEARCH;
            default:   step_state = (r_in_byte == CH_DOLLAR) ? S_DOLLAR : S_SEARCH;
        endcase
        // A newline that breaks a partial marker still starts a new line.
        if (step_state == S_SEARCH && r_in_byte == CH_NL) begin
            step_state = S_NEWLINE;
        end
    end

    always_comb begin
        closes          = (step_state == S_DONE) && r_open_valid;
        step_line       = r_line;
        step_open_id    = r_open_id;
        step_open_start = r_open_start;
        step_open_valid = r_open_valid;
        step_count      = r_count;

        closed_res.kind   = KIND_CLOSED;
        closed_res.id     = OUT_WIDTH'(r_open_id);
        closed_res.start  = OUT_WIDTH'(r_open_start);
        closed_res.length = OUT_WIDTH'(r_line - r_open_start);
        closed_res.number = r_count;
        closed_res.last   = !r_in_eof;

        if (step_state == S_NEWLINE) begin
            step_line = after;
        end else if (step_state == S_DONE) begin
            if (r_open_valid) begin
                step_count = r_count + 1'b1;
            end
            step_open_id    = r_id;
            step_open_start = after;
            step_line       = after;
            step_open_valid = 1'b1;
        end

        if (step_open_valid) begin
            final_res.kind   = KIND_FINAL;
            final_res.id     = OUT_WIDTH'(step_open_id);
            final_res.start  = OUT_WIDTH'(step_open_start);
            final_res.length = OUT_WIDTH'(step_line - step_open_start);
            final_res.number = step_count;
        end else begin
            final_res.kind   = KIND_EMPTY;
            final_res.id     = '0;
            final_res.start  = '0;
            final_res.length = '0;
            final_res.number = '0;
        end
        final_res.last = 1'b1;

        o_push.count  = {1'b0, closes} + {1'b0, r_in_eof};
        o_push.first  = closes ? closed_res : final_res;
        o_push.second = final_res;
        if (!fire) begin
            o_push.count = 2'd0;
        end

        // The last byte of a file leaves everything as after reset.
        if (r_in_eof) begin
            n_state      = S_SEARCH;
            n_id         = '0;
            n_pos        = '0;
            n_line       = '0;
            n_open_id    = '0;
            n_open_start = '0;
            n_open_valid = 1'b0;
            n_count      = '0;
        end else begin
            n_state      = step_state;
            n_id         = step_id;
            n_pos        = after;
            n_line       = step_line;
            n_open_id    = step_open_id;
            n_open_start = step_open_start;
            n_open_valid = step_open_valid;
            n_count      = step_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_eof  <= i_end_of_file;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SEARCH;
            r_id         <= '0;
            r_pos        <= '0;
            r_line       <= '0;
            r_open_id    <= '0;
            r_open_start <= '0;
            r_open_valid <= 1'b0;
            r_count      <= '0;
        end else if (fire) begin
            r_state      <= n_state;
            r_id         <= n_id;
            r_pos        <= n_pos;
            r_line       <= n_line;
            r_open_id    <= n_open_id;
            r_open_start <= n_open_start;
            r_open_valid <= n_open_valid;
            r_count      <= n_count;
        end
    end

endmodule

`default_nettype wire

### rtl/rmi_out_queue.sv
// Four-entry result queue that takes up to two results per cycle and gives one while i_ready is high.
// Depends on rmi_pkg; fed by rmi_scan.
`default_nettype none

module rmi_out_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  rmi_pkg::t_push      i_push,
    output logic                o_room,
    output logic                o_valid,
    input  wire logic           i_ready,
    output rmi_pkg::t_result    o_result
);
    import rmi_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_result            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_fill, n_fill;
    logic [PTR_W-1:0]   tail_next;
    logic               pop;

    // Room for a worst-case byte, not counting this cycle's pop.
    assign o_room    = r_fill <= CNT_W'(QUEUE_DEPTH - 2);
    assign o_valid   = r_fill != '0;
    assign o_result  = r_mem[r_head];
    assign pop       = o_valid && i_ready;
    assign tail_next = r_tail + 1'b1;

    always_comb begin
        n_head = pop ? r_head + 1'b1 : r_head;
        n_tail = r_tail + PTR_W'(i_push.count);
        n_fill = r_fill + CNT_W'(i_push.count) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_tail] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[tail_next] <= i_push.second;
        end
    end

endmodule

`default_nettype wire

### rtl/record_marker_indexer.sv
// Top level of the record marker indexer: byte input channel, result output channel.
// Depends on rmi_pkg, rmi_scan and rmi_out_queue.
//
// Usage: file bytes arrive one per beat on the input channel, with i_end_of_file
// set on the last byte. Each completed "$id:<digits>$" marker line closes the
// previous entry, if one is open, with a closed-entry result; the last byte
// yields the final entry, or a no-entries result when the file held no
// marker. A byte can cause two results; last_of_run marks the last one.
// Throughput: one byte per cycle while the result queue has room, set by the
// scan step between the input register and the result queue; one result
// per cycle leaves while i_out_ready is high. An accepted byte waits in the
// input register, is scanned there and its results are written to the queue.
// Stall: when the receiver holds i_out_ready low, the four-entry result queue
// fills; the scan step then holds its input register and o_in_ready drops.
// Reset (synchronous, active low) empties the queue and returns the scanner
// to the start of a new file. After the last byte the scanner does so by itself.
`default_nettype none

module record_marker_indexer #(
    parameter int unsigned POS_WIDTH = 32,
    parameter int unsigned ID_WIDTH  = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_end_of_file,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic [1:0]          o_record_kind,
    output logic [31:0]         o_entry_id,
    output logic [31:0]         o_entry_start,
    output logic [31:0]         o_entry_length,
    output logic [31:0]         o_entry_number,
    output logic                o_last_of_run
);
    import rmi_pkg::*;

    t_push   push;
    t_result head;
    logic    room;

    rmi_scan #(
        .POS_WIDTH (POS_WIDTH),
        .ID_WIDTH  (ID_WIDTH)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_end_of_file (i_end_of_file),
        .i_room        (room),
        .o_push        (push)
    );

    rmi_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (head)
    );

    assign o_record_kind  = head.kind;
    assign o_entry_id     = head.id;
    assign o_entry_start  = head.start;
    assign o_entry_length = head.length;
    assign o_entry_number = head.number;
    assign o_last_of_run  = head.last;

endmodule

`default_nettype wire

### rtl/rmi_checker.sv
// Port-level checks for record_marker_indexer, attached by the bind at the end.
// Depends on rmi_pkg for the result kind codes.
`default_nettype none

module rmi_checker (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           o_out_valid,
    input  wire logic           i_out_ready,
    input  wire logic [1:0]     o_record_kind,
    input  wire logic [31:0]    o_entry_id,
    input  wire logic [31:0]    o_entry_start,
    input  wire logic [31:0]    o_entry_length,
    input  wire logic [31:0]    o_entry_number,
    input  wire logic           o_last_of_run
);
    import rmi_pkg::*;

    // A result beat that is held back stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable({o_record_kind, o_entry_id,
            o_entry_start, o_entry_length, o_entry_number, o_last_of_run}))
        else $error("result payload changed while stalled");

    // The no-entries status carries zeros and ends its byte's results.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_record_kind == KIND_EMPTY |-> o_last_of_run &&
            o_entry_id == '0 && o_entry_start == '0 && o_entry_length == '0 &&
            o_entry_number == '0)
        else $error("no-entries result with nonzero fields");

    // A closed entry that does not end its run is followed at once by the final one.
    a_pair_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_record_kind == KIND_CLOSED && !o_last_of_run
            |=> o_out_valid && o_record_kind == KIND_FINAL && o_last_of_run)
        else $error("closed entry not followed by the final entry");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

endmodule

bind record_marker_indexer rmi_checker u_rmi_checker (.*);

`default_nettype wire
